// ----- sv/psii_pkg.sv -----
`default_nettype none
package psii_pkg;

  localparam int MAX_WIDTH_DEF    = 1024;
  localparam int MAX_HEIGHT_DEF   = 1024;
  localparam int MAX_FEATURES_DEF = 17;

  // position fields carried in commands, sized for the largest legal image
  localparam int COL_W  = 12;
  localparam int ROW_W  = 12;
  localparam int IV_W   = 50;
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic signed [14:0] feat;
    logic [4:0]         d;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic               first_row;
    logic               clr_pre;   // frame start: clear row sums first
    logic               clr_post;  // row end: clear row sums after
  } cmd_t;

  // base channel of feature d's product group
  function automatic logic [7:0] tri_base(input logic [4:0] d);
    logic [9:0] p;
    p = {5'd0, d} * ({5'd0, d} + 10'd1);
    return p[8:1];
  endfunction

endpackage
`default_nettype wire

// ----- sv/psii_front.sv -----
`default_nettype none
module psii_front #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_HEIGHT   = 1024,
  parameter int MAX_FEATURES = 17
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic signed [14:0]  in_feature_value,
  input  wire logic                in_frame_start,
  input  wire logic [10:0]         width_cfg,
  input  wire logic [4:0]          fcount_cfg,
  input  wire logic                q_full,
  output logic                     q_push,
  output psii_pkg::cmd_t           q_cmd
);
  import psii_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [4:0]    pos_r, pos_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          first_r, first_nxt;

  logic [12:0]   w_eff;
  logic [4:0]    nf_eff, d;
  logic [4:0]    pos_s;
  logic [CW-1:0] col_s;
  logic [RW-1:0] row_s;
  logic          first_s, pix_end, row_end, acc;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign q_push   = acc;

  always_comb begin
    if (width_cfg == 11'd0) w_eff = 13'd1;
    else if ({2'b0, width_cfg} > 13'(MAX_WIDTH)) w_eff = 13'(MAX_WIDTH);
    else w_eff = {2'b0, width_cfg};
    if (fcount_cfg == 5'd0) nf_eff = 5'd1;
    else if (fcount_cfg > 5'(MAX_FEATURES)) nf_eff = 5'(MAX_FEATURES);
    else nf_eff = fcount_cfg;

    pos_s   = in_frame_start ? '0 : pos_r;
    col_s   = in_frame_start ? '0 : col_r;
    row_s   = in_frame_start ? '0 : row_r;
    first_s = in_frame_start ? 1'b1 : first_r;

    d       = (pos_s > nf_eff - 5'd1) ? nf_eff - 5'd1 : pos_s;
    pix_end = (d >= nf_eff - 5'd1);
    row_end = pix_end && (13'(col_s) >= w_eff - 13'd1);

    pos_nxt   = pix_end ? 5'd0 : d + 5'd1;
    col_nxt   = row_end ? '0 : (pix_end ? col_s + CW'(1) : col_s);
    row_nxt   = row_s;
    first_nxt = first_s;
    if (row_end) begin
      if (32'(row_s) >= MAX_HEIGHT - 1) begin
        row_nxt   = '0;
        first_nxt = 1'b1;
      end else begin
        row_nxt   = row_s + RW'(1);
        first_nxt = 1'b0;
      end
    end

    q_cmd.feat      = in_feature_value;
    q_cmd.d         = d;
    q_cmd.col       = COL_W'(col_s);
    q_cmd.row       = ROW_W'(row_s);
    q_cmd.first_row = first_s;
    q_cmd.clr_pre   = in_frame_start;
    q_cmd.clr_post  = row_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      col_r   <= '0;
      row_r   <= '0;
      first_r <= 1'b1;
    end else if (acc) begin
      pos_r   <= pos_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      first_r <= first_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/psii_fifo.sv -----
`default_nettype none
module psii_fifo (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  psii_pkg::cmd_t din,
  output logic           full,
  input  wire logic      pop,
  output logic           empty,
  output psii_pkg::cmd_t dout
);
  import psii_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  cmd_t        mem_r [QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign full  = (cnt_r == (PW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PW'(1);
      if (pop)  rp_r <= rp_r + PW'(1);
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

// ----- sv/psii_back.sv -----
`default_nettype none
module psii_back #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_FEATURES = 17
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  psii_pkg::cmd_t         q_cmd,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [49:0]     out_integral_value,
  output logic                   out_result_kind,
  output logic [4:0]             out_first_feature,
  output logic [4:0]             out_second_feature,
  output logic [9:0]             out_pixel_row,
  output logic [9:0]             out_pixel_column,
  output logic                   out_last_result
);
  import psii_pkg::*;

  localparam int NPROD = MAX_FEATURES * (MAX_FEATURES + 1) / 2;
  localparam int NCHAN = NPROD + MAX_FEATURES;
  localparam int CH_W  = $clog2(NCHAN);
  localparam int DEPTH = MAX_WIDTH * NCHAN;
  localparam int PA_W  = $clog2(DEPTH);
  localparam int FI_W  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADDR = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]   state_r;
  cmd_t         cur_r;
  logic [4:0]   k_r;
  logic         sum_r;
  logic [CH_W-1:0] ch_r;
  logic [PA_W-1:0] pa_r;
  logic signed [IV_W-1:0] term_r, acc_rd_r, prev_rd_r;
  logic         vld_rd_r;
  logic [NCHAN-1:0] acc_vld_r;

  logic signed [14:0] feat_r [MAX_FEATURES];
  logic [IV_W-1:0] acc_mem [NCHAN];
  logic [IV_W-1:0] prev_mem [DEPTH];

  logic          is_sum, slot_free, do_exec;
  logic [CH_W-1:0] ch_s;
  logic [PA_W-1:0] pa_s;
  logic [FI_W-1:0] kidx;
  logic signed [29:0] prod;
  logic signed [IV_W-1:0] term_s, acc_new, above, val;

  logic signed [IV_W-1:0] oval_r;
  logic        ovalid_r, okind_r, olast_r;
  logic [4:0]  ofirst_r, osecond_r;
  logic [9:0]  orow_r, ocol_r;

  assign slot_free = !ovalid_r || !out_stall;
  assign do_exec   = (state_r == S_EXEC) && slot_free;
  assign q_pop     = (state_r == S_IDLE) && !q_empty;

  always_comb begin
    is_sum = (k_r == cur_r.d + 5'd1);
    kidx   = is_sum ? '0 : FI_W'(k_r);
    if (is_sum) ch_s = CH_W'(NPROD + 32'(cur_r.d));
    else        ch_s = CH_W'(32'(tri_base(cur_r.d)) + 32'(k_r));
    pa_s   = PA_W'(32'(cur_r.col) * NCHAN + 32'(ch_s));
    prod   = feat_r[kidx] * cur_r.feat;
    term_s = is_sum ? IV_W'(cur_r.feat) : IV_W'(prod);

    acc_new = (vld_rd_r ? acc_rd_r : '0) + term_r;
    above   = cur_r.first_row ? '0 : prev_rd_r;
    val     = acc_new + above;
  end

  // memory ports: one registered read and one write each
  always_ff @(posedge clk) begin
    if (state_r == S_ADDR) begin
      acc_rd_r  <= acc_mem[ch_s];
      prev_rd_r <= prev_mem[pa_s];
      vld_rd_r  <= acc_vld_r[ch_s];
      term_r    <= term_s;
      ch_r      <= ch_s;
      pa_r      <= pa_s;
      sum_r     <= is_sum;
    end
    if (do_exec) begin
      acc_mem[ch_r]  <= acc_new;
      prev_mem[pa_r] <= val;
    end
    if (q_pop) cur_r <= q_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      k_r       <= '0;
      acc_vld_r <= '0;
      ovalid_r  <= 1'b0;
      for (int i = 0; i < MAX_FEATURES; i++) feat_r[i] <= '0;
    end else begin
      // result register: loads on an executed step, empties once taken
      if (slot_free) ovalid_r <= do_exec;
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            if (q_cmd.clr_pre) acc_vld_r <= '0;
            feat_r[FI_W'(q_cmd.d)] <= q_cmd.feat;
            k_r     <= '0;
            state_r <= S_ADDR;
          end
        end
        S_ADDR: state_r <= S_EXEC;
        S_EXEC: begin
          if (slot_free) begin
            oval_r    <= val;
            okind_r   <= sum_r;
            olast_r   <= sum_r;
            ofirst_r  <= sum_r ? cur_r.d : k_r;
            osecond_r <= cur_r.d;
            orow_r    <= cur_r.row[9:0];
            ocol_r    <= cur_r.col[9:0];
            if (sum_r) begin
              if (cur_r.clr_post) acc_vld_r <= '0;
              else acc_vld_r[ch_r] <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              acc_vld_r[ch_r] <= 1'b1;
              k_r     <= k_r + 5'd1;
              state_r <= S_ADDR;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = ovalid_r;
  assign out_integral_value = oval_r;
  assign out_result_kind    = okind_r;
  assign out_first_feature  = ofirst_r;
  assign out_second_feature = osecond_r;
  assign out_pixel_row      = orow_r;
  assign out_pixel_column   = ocol_r;
  assign out_last_result    = olast_r;

endmodule
`default_nettype wire

// ----- sv/product_sum_integral_image.sv -----
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_stall   feature_value, frame_start
// out_      output     out_valid / out_stall integral value, kind, indices, position
// cfg       input      psel/penable/pwrite   image_width @0, feature_count @4
//
// Feature d of a pixel gives d+2 results, each a read-add-write of the
// row-sum and line-buffer memories, one channel at a time; the next item
// is dequeued only once the last result of the previous item is registered.
// Reset (rst_n low, synchronous) clears positions, row-sum valid bits and the
// command queue; the line buffer is not cleared and holds junk until written.
// A two-entry command queue parts classification from integration, so input
// is taken until the queue fills while out_stall holds the result register.
`default_nettype none
module product_sum_integral_image #(
  parameter int MAX_WIDTH    = psii_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT   = psii_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_FEATURES = psii_pkg::MAX_FEATURES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic signed [14:0] in_feature_value,
  input  wire logic              in_frame_start,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [49:0]     out_integral_value,
  output logic                   out_result_kind,
  output logic [4:0]             out_first_feature,
  output logic [4:0]             out_second_feature,
  output logic [9:0]             out_pixel_row,
  output logic [9:0]             out_pixel_column,
  output logic                   out_last_result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import psii_pkg::*;

  // register index from byte address
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_FCOUNT = 1'b1;

  logic [10:0] width_r;
  logic [4:0]  fcount_r;
  logic        cfg_wr;

  cmd_t        push_cmd, pop_cmd;
  logic        q_push, q_pop, q_full, q_empty;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd1024;
      fcount_r <= 5'd7;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_WIDTH:  width_r  <= pwdata[10:0];
        REG_FCOUNT: fcount_r <= pwdata[4:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = {21'd0, width_r};
      REG_FCOUNT: prdata = {27'd0, fcount_r};
    endcase
  end

  // front: positions, clamping, row/frame bookkeeping
  psii_front #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_FEATURES(MAX_FEATURES)
  ) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_feature_value, .in_frame_start,
    .width_cfg(width_r), .fcount_cfg(fcount_r),
    .q_full, .q_push, .q_cmd(push_cmd)
  );

  psii_fifo u_fifo (
    .clk, .rst_n, .push(q_push), .din(push_cmd), .full(q_full),
    .pop(q_pop), .empty(q_empty), .dout(pop_cmd)
  );

  // back: product, row sum and line buffer update, result register
  psii_back #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_FEATURES(MAX_FEATURES)
  ) u_back (
    .clk, .rst_n, .q_empty, .q_cmd(pop_cmd), .q_pop,
    .out_valid, .out_stall, .out_integral_value, .out_result_kind,
    .out_first_feature, .out_second_feature, .out_pixel_row,
    .out_pixel_column, .out_last_result
  );

endmodule
`default_nettype wire

// ----- sv/psii_checker.sv -----
`default_nettype none
module psii_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [49:0] out_integral_value,
  input wire logic        out_result_kind,
  input wire logic [4:0]  out_first_feature,
  input wire logic [4:0]  out_second_feature,
  input wire logic        out_last_result
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_integral_value))
    else $error("stalled result changed");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_result == out_result_kind))
    else $error("last flag not on the plain sum");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_kind |-> out_first_feature <= out_second_feature)
    else $error("product pair out of order");

  a_sum_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind |-> out_first_feature == out_second_feature)
    else $error("plain sum index mismatch");

endmodule

bind product_sum_integral_image psii_checker u_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_integral_value,
  .out_result_kind, .out_first_feature, .out_second_feature, .out_last_result
);
`default_nettype wire

// ----- dv/product_sum_integral_image_checker.sv -----
`timescale 1ns / 100ps
module product_sum_integral_image_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic signed [14:0] in_feature_value,
  input  wire logic               in_frame_start,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic signed [49:0] out_integral_value,
  input  wire logic               out_result_kind,
  input  wire logic [4:0]         out_first_feature,
  input  wire logic [4:0]         out_second_feature,
  input  wire logic [9:0]         out_pixel_row,
  input  wire logic [9:0]         out_pixel_column,
  input  wire logic               out_last_result,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  input  wire logic               pready,
  output int                      fail_count,
  output int                      pending_count,
  output int                      result_count
);
  localparam int MAXW = 1024;
  localparam int MAXH = 1024;
  localparam int MAXF = 17;
  localparam int NPROD = MAXF * (MAXF + 1) / 2;
  localparam int NCHAN = NPROD + MAXF;
  localparam logic [2:0] ADDR_WIDTH = 3'd0;
  localparam logic [2:0] ADDR_FEATURES = 3'd4;

  typedef struct packed {
    logic [49:0] value;
    logic        kind;
    logic [4:0]  f1;
    logic [4:0]  f2;
    logic [9:0]  row;
    logic [9:0]  col;
    logic        last;
  } integral_t;

  integral_t expected_q[$];
  logic [49:0] line_buf[int];
  logic [49:0] row_sum[NCHAN];
  logic signed [14:0] pix_feat[MAXF];
  int feat_pos, col_pos, row_pos;
  bit first_row;
  logic [10:0] width_reg;
  logic [4:0] count_reg;

  function automatic logic [49:0] integrate(int col, int ch, logic [49:0] term);
    logic [49:0] above;
    logic [49:0] v;
    above = 50'd0;
    row_sum[ch] = row_sum[ch] + term;
    if (!first_row && line_buf.exists(col * NCHAN + ch)) above = line_buf[col * NCHAN + ch];
    v = row_sum[ch] + above;
    line_buf[col * NCHAN + ch] = v;
    return v;
  endfunction

  task automatic predict_integrals(logic signed [14:0] f, logic fs);
    int nf, w, d, col, ch;
    logic signed [31:0] p;
    integral_t r;
    if (fs) begin
      feat_pos = 0; col_pos = 0; row_pos = 0; first_row = 1;
      foreach (row_sum[i]) row_sum[i] = '0;
    end
    nf = count_reg; if (nf < 1) nf = 1; if (nf > MAXF) nf = MAXF;
    w = width_reg; if (w < 1) w = 1; if (w > MAXW) w = MAXW;
    d = feat_pos; if (d > nf - 1) d = nf - 1;
    col = col_pos; if (col > MAXW - 1) col = MAXW - 1;
    pix_feat[d] = f;
    for (int k = 0; k <= d + 1; k++) begin
      r.row = row_pos[9:0]; r.col = col[9:0]; r.f2 = d[4:0];
      if (k <= d) begin
        p = pix_feat[k] * f;
        ch = d * (d + 1) / 2 + k;
        r.value = integrate(col, ch, {{18{p[31]}}, p});
        r.kind = 0; r.f1 = k[4:0]; r.last = 0;
      end else begin
        r.value = integrate(col, NPROD + d, {{35{f[14]}}, f});
        r.kind = 1; r.f1 = d[4:0]; r.last = 1;
      end
      expected_q.push_back(r);
    end
    if (d >= nf - 1) begin
      feat_pos = 0;
      if (col >= w - 1) begin
        col_pos = 0;
        foreach (row_sum[i]) row_sum[i] = '0;
        if (row_pos >= MAXH - 1) begin
          row_pos = 0; first_row = 1;
        end else begin
          row_pos++; first_row = 0;
        end
      end else begin
        col_pos = col + 1;
      end
    end else begin
      feat_pos = d + 1;
    end
  endtask

  always @(posedge clk) begin
    integral_t got, exp_r;
    if (!rst_n) begin
      width_reg = 11'd1024; count_reg = 5'd7;
      feat_pos = 0; col_pos = 0; row_pos = 0; first_row = 1;
      foreach (row_sum[i]) row_sum[i] = '0;
      foreach (pix_feat[i]) pix_feat[i] = '0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_WIDTH) width_reg = pwdata[10:0];
        else if (paddr == ADDR_FEATURES) count_reg = pwdata[4:0];
      end
      if (out_valid && !out_stall) begin
        got = '{out_integral_value, out_result_kind, out_first_feature,
                out_second_feature, out_pixel_row, out_pixel_column, out_last_result};
        result_count++;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %p", got);
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p got %p", exp_r, got);
          end
        end
      end
      if (in_valid && !in_stall) predict_integrals(in_feature_value, in_frame_start);
    end
    pending_count = expected_q.size();
  end

  initial begin
    fail_count = 0; pending_count = 0; result_count = 0;
  end
endmodule

// ----- dv/product_sum_integral_image_tb.sv -----
`timescale 1ns / 100ps
module product_sum_integral_image_tb;
  localparam logic [2:0] ADDR_WIDTH = 3'd0;
  localparam logic [2:0] ADDR_FEATURES = 3'd4;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic signed [14:0] in_feature_value = '0;
  logic in_frame_start = 0;
  logic out_stall = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  wire in_stall, out_valid, out_result_kind, out_last_result, pready;
  wire signed [49:0] out_integral_value;
  wire [4:0] out_first_feature, out_second_feature;
  wire [9:0] out_pixel_row, out_pixel_column;
  wire [31:0] prdata;
  int fail_count, pending_count, result_count;
  int items_sent = 0;
  int idle_cycles = 0;
  bit calm = 0;      // no idling in the final stretch
  bit long_hold = 0; // receiver holds off to fill the block

  always #5 clk = ~clk;

  product_sum_integral_image DUT (.*);

  product_sum_integral_image_checker checker_i (.*);

  // receiver: random stall bursts, a long hold on request
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall <= 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 15);
        out_stall <= 1;
        repeat (n) @(negedge clk);
        out_stall <= 0;
      end else begin
        out_stall <= 0;
      end
    end
  end

  // watchdog: cycles with nothing accepted
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("product_sum_integral_image_tb: FAIL");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // offer one item, hold until taken; optional idle burst first.
  // valid stays up on return: the next call or drain replaces or drops it
  task automatic send_feature(logic signed [14:0] v, logic fs);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid <= 1; in_feature_value <= v; in_frame_start <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (pending_count != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  function automatic logic signed [14:0] rand_feature();
    case ($urandom_range(0, 5))
      0: return 15'sh4000;
      1: return 15'sh3fff;
      default: return 15'($urandom);
    endcase
  endfunction

  // whole frame rows of random pixels; frame start on the first item
  task automatic send_pixels(int npix, int nf);
    for (int p = 0; p < npix; p++)
      for (int d = 0; d < nf; d++)
        send_feature(rand_feature(), (p == 0 && d == 0));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: reset setting, extremes of the value field, frame start
    send_feature(15'sh4000, 1);
    send_feature(15'sh3fff, 0);
    send_feature(15'sh4000, 0);
    send_feature(15'sh0000, 0);
    send_feature(15'sh7fff, 0);
    send_feature(15'sh0001, 0);
    send_feature(15'sh3fff, 0);
    drain();
    // narrow image, one feature: rows wrap quickly and line buffer is read
    cfg_write(ADDR_WIDTH, 2);
    cfg_write(ADDR_FEATURES, 1);
    send_pixels(6, 1);
    drain();
    // out-of-range registers: width 0 acts as 1, count 0 as 1, 31 as max
    cfg_write(ADDR_WIDTH, 0);
    cfg_write(ADDR_FEATURES, 31);
    send_pixels(1, 17);
    drain();
    cfg_write(ADDR_FEATURES, 0);
    send_pixels(3, 1);
    drain();

    // long receiver hold while the sender keeps offering
    cfg_write(ADDR_WIDTH, 3);
    cfg_write(ADDR_FEATURES, 4);
    long_hold = 1;
    fork
      send_pixels(3, 4);
      begin
        repeat (300) @(negedge clk);
        long_hold = 0;
      end
    join
    drain();

    // random phases over several settings, the largest width among them
    for (int ph = 0; ph < 4; ph++) begin
      cfg_write(ADDR_WIDTH, ph == 3 ? 2047 : $urandom_range(1, 4));
      cfg_write(ADDR_FEATURES, ph == 0 ? 17 : $urandom_range(1, 5));
      if (ph == 3) calm = 1;
      for (int i = 0; i < 15; i++)
        send_feature(rand_feature(), (i == 0) || ($urandom_range(0, 19) == 0));
      drain();
    end

    $display("covered %0d items, %0d results; widths 0..2047, features 0..31,",
             items_sent, result_count);
    $display("frame starts, row wraps, a long output hold and full drains");
    if (fail_count == 0) $display("product_sum_integral_image_tb: PASS");
    else $display("product_sum_integral_image_tb: FAIL");
    $finish;
  end
endmodule

// ----- sim.f -----
sv/psii_pkg.sv
sv/psii_front.sv
sv/psii_fifo.sv
sv/psii_back.sv
sv/product_sum_integral_image.sv
sv/psii_checker.sv
dv/product_sum_integral_image_checker.sv
dv/product_sum_integral_image_tb.sv
